// ===== src/sib_pkg.sv =====
`default_nettype none
package sib_pkg;
	localparam int unsigned TickW = 32;
	localparam int unsigned PosW  = 32;
	localparam int unsigned RtW   = 48;
	localparam int unsigned DivW  = 17;

	localparam logic [1:0] RegStart = 2'd0;
	localparam logic [1:0] RegDelay = 2'd1;
	localparam logic [1:0] RegRate  = 2'd2;

	typedef struct packed {
		logic [TickW-1:0] tick;
		logic [PosW-1:0]  x;
		logic [PosW-1:0]  y;
	} snap_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rd_oldest;
		logic rd_second;
		logic rd_newest;
		logic do_write;
		logic do_start;
		logic do_lo_clamp;
		logic do_advance;
		logic do_drop;
		logic div_start;
		logic do_blend;
		logic out_held;
		logic out_blend;
		logic out_empty;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic running;
		logic stale;
		logic can_drop;
		logic hold_first;
		logic div_done;
	} stat_t;
endpackage
`default_nettype wire

// ===== src/sib_ctrl.sv =====
`default_nettype none
module sib_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire              kind,
	output logic             busy,
	output sib_pkg::cmd_t    cmd,
	input  sib_pkg::stat_t   stat
);
	import sib_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ARD    = 4'd1;
	localparam logic [3:0] S_ACHK   = 4'd2;
	localparam logic [3:0] S_ASTART = 4'd3;
	localparam logic [3:0] S_ARDLO  = 4'd4;
	localparam logic [3:0] S_ALO    = 4'd5;
	localparam logic [3:0] S_TRD    = 4'd6;
	localparam logic [3:0] S_TADV   = 4'd7;
	localparam logic [3:0] S_TRD2   = 4'd8;
	localparam logic [3:0] S_TCHK   = 4'd9;
	localparam logic [3:0] S_TDIV   = 4'd10;
	localparam logic [3:0] S_TBLD   = 4'd11;
	localparam logic [3:0] S_TOUT   = 4'd12;
	localparam logic [3:0] S_TRDH   = 4'd13;
	localparam logic [3:0] S_THELD  = 4'd14;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!kind) begin
						cmd.rd_newest = 1'b1;
						state_d = S_ARD;
					end else if (stat.empty) begin
						cmd.out_empty = 1'b1;
					end else if (!stat.running) begin
						cmd.rd_oldest = 1'b1;
						state_d = S_THELD;
					end else begin
						cmd.rd_newest = 1'b1;
						state_d = S_TRD;
					end
				end
			end
			S_ARD: state_d = S_ACHK;
			S_ACHK: begin
				if (stat.stale) begin
					state_d = S_IDLE;
				end else begin
					cmd.do_write = 1'b1;
					state_d = S_ASTART;
				end
			end
			S_ASTART: begin
				cmd.do_start = 1'b1;
				cmd.rd_oldest = 1'b1;
				state_d = S_ARDLO;
			end
			S_ARDLO: state_d = S_ALO;
			S_ALO: begin
				cmd.do_lo_clamp = 1'b1;
				state_d = S_IDLE;
			end
			S_TRD: state_d = S_TADV;
			S_TADV: begin
				cmd.do_advance = 1'b1;
				cmd.rd_second = 1'b1;
				cmd.rd_oldest = 1'b1;
				state_d = S_TRD2;
			end
			S_TRD2: state_d = S_TCHK;
			S_TCHK: begin
				if (stat.can_drop) begin
					cmd.do_drop = 1'b1;
					state_d = S_TRDH;
				end else if (stat.hold_first) begin
					cmd.out_held = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_TDIV;
				end
			end
			S_TRDH: begin
				cmd.rd_second = 1'b1;
				cmd.rd_oldest = 1'b1;
				state_d = S_TRD2;
			end
			S_TDIV: if (stat.div_done) state_d = S_TBLD;
			S_TBLD: begin
				cmd.do_blend = 1'b1;
				state_d = S_TOUT;
			end
			S_TOUT: begin
				cmd.out_blend = 1'b1;
				state_d = S_IDLE;
			end
			S_THELD: begin
				cmd.out_held = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== src/sib_dp.sv =====
`default_nettype none
module sib_dp #(
	parameter int unsigned RING_DEPTH = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  sib_pkg::cmd_t              cmd,
	output sib_pkg::stat_t             stat,
	input  wire                        start,
	input  wire                        busy,
	input  wire [sib_pkg::TickW-1:0]   snap_tick,
	input  wire signed [sib_pkg::PosW-1:0] snap_x,
	input  wire signed [sib_pkg::PosW-1:0] snap_y,
	input  wire signed [31:0]          elapsed,
	input  wire [4:0]                  start_count,
	input  wire [7:0]                  delay_ticks,
	input  wire [10:0]                 tick_rate,
	output logic                       result_valid,
	output logic                       have_position,
	output logic signed [sib_pkg::PosW-1:0] out_x,
	output logic signed [sib_pkg::PosW-1:0] out_y
);
	import sib_pkg::*;

	localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);

	snap_t ring_q [RING_DEPTH];
	snap_t rd_a_q, rd_b_q;

	logic [AW-1:0]     oldest_q;
	logic [CW-1:0]     count_q;
	logic              running_q;
	logic [RtW-1:0]    rt_q;

	logic [TickW-1:0]  in_tick_q;
	logic [PosW-1:0]   in_x_q, in_y_q;
	logic [31:0]       el_q;

	logic [DivW-1:0]   a_q;
	logic [5:0]        div_cnt_q;
	logic [RtW-1:0]    rem_q;
	logic [RtW-1:0]    num_q;
	logic [TickW-1:0]  den_q;
	logic              div_busy_q;

	logic signed [PosW-1:0] bx_q, by_q;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [CW-1:0] i);
		logic [AW+CW:0] s;
		s = {{(CW+1){1'b0}}, b} + {{(AW+1){1'b0}}, i};
		if (s >= (AW+CW+1)'(RING_DEPTH)) s = s - (AW+CW+1)'(RING_DEPTH);
		return s[AW-1:0];
	endfunction

	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic          rd_en_a, rd_en_b;
	logic [CW-1:0] cnt_m1;
	assign cnt_m1 = count_q - CW'(1);

	always_comb begin
		rd_en_a = cmd.rd_newest | cmd.rd_oldest;
		rd_addr_a = cmd.rd_newest ? slot(oldest_q, cnt_m1) : oldest_q;
		rd_en_b = cmd.rd_second;
		rd_addr_b = slot(oldest_q, CW'(1));
	end

	// In the tick sequence the newest entry is read first and then the
	// oldest, so the cap value is captured in its own register.
	logic [RtW-1:0] cap_q;
	logic           cap_pend_q;

	logic [AW-1:0] wr_slot;
	logic          full;
	assign full = (count_q == CW'(RING_DEPTH));
	assign wr_slot = full ? oldest_q : slot(oldest_q, count_q);

	always_ff @(posedge clk) begin
		if (cmd.do_write) ring_q[wr_slot] <= '{tick: in_tick_q, x: in_x_q, y: in_y_q};
		if (rd_en_a) rd_a_q <= ring_q[rd_addr_a];
		if (rd_en_b) rd_b_q <= ring_q[rd_addr_b];
	end

	logic [RtW-1:0] a_tick_rt, b_tick_rt;
	assign a_tick_rt = {rd_a_q.tick, 16'd0};
	assign b_tick_rt = {rd_b_q.tick, 16'd0};

	logic [CW-1:0] new_count;
	assign new_count = full ? count_q : count_q + CW'(1);

	logic [TickW:0] st_diff;
	assign st_diff = {1'b0, in_tick_q} - {25'd0, delay_ticks};

	logic [42:0] adv;
	assign adv = el_q[31] ? 43'd0 : el_q * {21'd0, tick_rate};
	logic [RtW:0] rt_sum;
	assign rt_sum = {1'b0, rt_q} + {6'd0, adv};

	logic start_ok;
	assign start_ok = ({{(32-CW){1'b0}}, count_q} >= {27'd0, start_count});

	assign stat.empty = (count_q == '0);
	assign stat.running = running_q;
	assign stat.stale = (count_q != '0) && (in_tick_q <= rd_a_q.tick);
	assign stat.can_drop = (count_q >= CW'(2)) && (b_tick_rt <= rt_q);
	assign stat.hold_first = (count_q == CW'(1)) || (rt_q <= a_tick_rt);
	assign stat.div_done = !div_busy_q;

	// Restoring division: 48-bit numerator over 32-bit tick difference.
	logic [RtW:0] trial;
	assign trial = {rem_q, num_q[RtW-1]} - {17'd0, den_q};

	logic signed [PosW:0] dx, dy;
	assign dx = $signed({rd_b_q.x[PosW-1], rd_b_q.x}) - $signed({rd_a_q.x[PosW-1], rd_a_q.x});
	assign dy = $signed({rd_b_q.y[PosW-1], rd_b_q.y}) - $signed({rd_a_q.y[PosW-1], rd_a_q.y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q <= '0;
			running_q <= 1'b0;
			rt_q <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
			result_valid <= 1'b0;
			cap_pend_q <= 1'b0;
		end else begin
			result_valid <= cmd.out_empty | cmd.out_held | cmd.out_blend;
			if (cmd.do_write) begin
				if (full) oldest_q <= slot(oldest_q, CW'(1));
				count_q <= new_count;
			end
			if (cmd.do_start && !running_q && start_ok) begin
				rt_q <= st_diff[TickW] ? '0 : {st_diff[TickW-1:0], 16'd0};
				running_q <= 1'b1;
			end
			if (cmd.do_lo_clamp && running_q && rt_q < a_tick_rt) rt_q <= a_tick_rt;
			cap_pend_q <= cmd.rd_newest;
			if (cap_pend_q) cap_q <= a_tick_rt;
			if (cmd.do_advance) begin
				if (rt_sum > {1'b0, cap_q}) rt_q <= cap_q;
				else rt_q <= rt_sum[RtW-1:0];
			end
			if (cmd.do_drop) begin
				oldest_q <= slot(oldest_q, CW'(1));
				count_q <= cnt_m1;
			end
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= 6'(RtW);
				num_q <= rt_q - a_tick_rt;
				den_q <= rd_b_q.tick - rd_a_q.tick;
				rem_q <= '0;
				a_q <= '0;
			end else if (div_busy_q) begin
				// Once the quotient outgrows its register it sticks at all ones.
				if (!trial[RtW]) begin
					rem_q <= trial[RtW-1:0];
					a_q <= a_q[DivW-1] ? '1 : {a_q[DivW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[RtW-2:0], num_q[RtW-1]};
					a_q <= a_q[DivW-1] ? '1 : {a_q[DivW-2:0], 1'b0};
				end
				num_q <= {num_q[RtW-2:0], 1'b0};
				div_cnt_q <= div_cnt_q - 6'd1;
				if (div_cnt_q == 6'd1) div_busy_q <= 1'b0;
			end
		end
	end

	// Saturating quotient: any quotient of 65536 or more clamps to one.
	logic [DivW-1:0] a_cl;
	assign a_cl = (a_q > DivW'(65536)) ? DivW'(65536) : a_q;
	logic signed [PosW+DivW+1:0] pxc, pyc;
	assign pxc = dx * $signed({1'b0, a_cl});
	assign pyc = dy * $signed({1'b0, a_cl});

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			in_tick_q <= snap_tick;
			in_x_q <= snap_x;
			in_y_q <= snap_y;
			el_q <= elapsed;
		end
		if (cmd.do_blend) begin
			bx_q <= PosW'($signed(rd_a_q.x) + PosW'((pxc + (PosW+DivW+2)'(32768)) >>> 16));
			by_q <= PosW'($signed(rd_a_q.y) + PosW'((pyc + (PosW+DivW+2)'(32768)) >>> 16));
		end
		if (cmd.out_empty) begin
			have_position <= 1'b0;
			out_x <= '0;
			out_y <= '0;
		end else if (cmd.out_held) begin
			have_position <= 1'b1;
			out_x <= rd_a_q.x;
			out_y <= rd_a_q.y;
		end else if (cmd.out_blend) begin
			have_position <= 1'b1;
			out_x <= bx_q;
			out_y <= by_q;
		end
	end
endmodule
`default_nettype wire

// ===== src/snapshot_interpolation_buffer_top.sv =====
`default_nettype none
// Snapshot interpolation buffer. Issue an item with start while busy is low;
// busy stays high while an add item checks its tick (ending there if stale),
// writes and starts, and while a tick item advances, drops old snapshots and,
// to blend, runs the 48-step serial divider for the blend factor. An empty or
// not yet running buffer answers a tick item without the divider. The result
// appears for one cycle with done high and cannot be held.
module snapshot_interpolation_buffer_top #(
	parameter int unsigned RING_DEPTH = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               kind,
	input  wire [31:0]        snap_tick,
	input  wire signed [31:0] snap_x,
	input  wire signed [31:0] snap_y,
	input  wire signed [31:0] elapsed,
	output logic              done,
	output logic              have_position,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [3:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import sib_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [4:0]  start_count_q;
	logic [7:0]  delay_q;
	logic [10:0] rate_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_count_q <= 5'd3;
			delay_q <= 8'd2;
			rate_q <= 11'd60;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				RegStart: start_count_q <= pwdata[4:0];
				RegDelay: delay_q <= pwdata[7:0];
				RegRate:  rate_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			RegStart: prdata = {27'd0, start_count_q};
			RegDelay: prdata = {24'd0, delay_q};
			RegRate:  prdata = {21'd0, rate_q};
			default:  prdata = '0;
		endcase
	end

	sib_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.busy(busy), .cmd(cmd), .stat(stat)
	);

	sib_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.start(start), .busy(busy),
		.snap_tick(snap_tick), .snap_x(snap_x), .snap_y(snap_y), .elapsed(elapsed),
		.start_count(start_count_q), .delay_ticks(delay_q), .tick_rate(rate_q),
		.result_valid(done), .have_position(have_position), .out_x(out_x), .out_y(out_y)
	);

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(start && !busy && !kind)) else $error("result after add item");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.out_empty, cmd.out_held, cmd.out_blend})) else $error("two results");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !have_position) |-> (out_x == 0 && out_y == 0)) else $error("empty nonzero");
`endif
endmodule
`default_nettype wire
